// ===== design/ieq_pkg.sv =====
// Shared types and constants for the input event capture queue.
// Depends on nothing; used by every module of the block.
package ieq_pkg;
	localparam int DefaultDepth = 128;
	localparam logic [63:0] TestHash = 64'h5253484152450001;

	localparam logic [1:0] ModeKey   = 2'd0;
	localparam logic [1:0] ModeMouse = 2'd1;
	localparam logic [1:0] ModeTest  = 2'd2;
	localparam logic [1:0] ModeRead  = 2'd3;

	localparam logic [7:0] KindKeyboard = 8'd1;
	localparam logic [7:0] KindMouse    = 8'd2;
	localparam logic [7:0] EvKey    = 8'd0;
	localparam logic [7:0] EvMove   = 8'd1;
	localparam logic [7:0] EvButton = 8'd2;
	localparam logic [7:0] EvWheel  = 8'd3;

	// One stored event: everything but the instance hash, which is rebuilt on read.
	typedef struct packed {
		logic        source;
		logic [7:0]  dkind;
		logic [7:0]  ekind;
		logic [15:0] flags;
		logic [63:0] id;
		logic [31:0] v0;
		logic [31:0] v1;
		logic [15:0] v2;
		logic [63:0] t;
	} evt_t;

	// Command handed from the front to the back.
	typedef struct packed {
		logic  is_read;
		evt_t  ev;
	} cmd_t;

	// Button order: left, middle, right, 4, 5 -> down bit index.
	function automatic logic [3:0] btn_down_bit(input logic [2:0] k);
		case (k)
			3'd0: btn_down_bit = 4'd0;
			3'd1: btn_down_bit = 4'd4;
			3'd2: btn_down_bit = 4'd2;
			3'd3: btn_down_bit = 4'd6;
			default: btn_down_bit = 4'd8;
		endcase
	endfunction
endpackage

// ===== design/ieq_front.sv =====
// Front part: takes packets and breaks them into single events or reads.
// Depends on ieq_pkg.
module ieq_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          mode,
	input  logic [15:0]         unit_id,
	input  logic [47:0]         device_handle,
	input  logic [15:0]         packet_flags,
	input  logic [15:0]         make_code,
	input  logic [15:0]         button_flags,
	input  logic [15:0]         button_data,
	input  logic [31:0]         delta_x,
	input  logic [31:0]         delta_y,
	input  logic [63:0]         time_us,
	input  logic [7:0]          test_device_kind,
	input  logic [7:0]          test_event_kind,
	output logic                cmd_valid,
	input  logic                cmd_ready,
	output ieq_pkg::cmd_t       cmd
);
	// Held packet and the set of mouse events still to be issued
	// (bit 0 move, 1..5 buttons, 6 vertical wheel, 7 horizontal wheel).
	logic        busy_q;
	logic [1:0]  mode_q;
	logic [15:0] pflags_q, make_q, bflags_q, bdata_q;
	logic [31:0] dx_q, dy_q;
	logic [63:0] id_q, t_q;
	logic [7:0]  tdk_q, tek_q;
	logic [7:0]  pend_q;
	logic [2:0]  sel;
	logic [7:0]  pend_new;
	logic [31:0] wheel;
	logic        take;
	logic        last;
	logic [3:0]  db;

	assign in_ready = !busy_q;
	assign take = in_valid && in_ready;
	assign wheel = {{16{bdata_q[15]}}, bdata_q};

	always_comb begin
		sel = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (pend_q[i]) sel = i[2:0];
		end
	end

	always_comb begin
		pend_new = pend_q;
		pend_new[sel] = 1'b0;
	end

	assign last = (mode_q != ieq_pkg::ModeMouse) || (pend_new == 8'd0);
	assign cmd_valid = busy_q && ((mode_q != ieq_pkg::ModeMouse) || (pend_q != 8'd0));
	assign db = ieq_pkg::btn_down_bit(sel - 3'd1);

	always_comb begin
		cmd = '0;
		cmd.is_read = (mode_q == ieq_pkg::ModeRead);
		cmd.ev.t = t_q;
		cmd.ev.flags = pflags_q;
		cmd.ev.id = id_q;
		unique case (mode_q)
			ieq_pkg::ModeKey: begin
				cmd.ev.dkind = ieq_pkg::KindKeyboard;
				cmd.ev.ekind = ieq_pkg::EvKey;
				cmd.ev.v0 = {16'd0, make_q};
				cmd.ev.v1 = {31'd0, !pflags_q[0]};
				cmd.ev.v2 = pflags_q;
			end
			ieq_pkg::ModeMouse: begin
				cmd.ev.dkind = ieq_pkg::KindMouse;
				cmd.ev.v2 = bflags_q;
				if (sel == 3'd0) begin
					cmd.ev.ekind = ieq_pkg::EvMove;
					cmd.ev.v0 = dx_q;
					cmd.ev.v1 = dy_q;
					cmd.ev.v2 = pflags_q;
				end else if (sel == 3'd6) begin
					cmd.ev.ekind = ieq_pkg::EvWheel;
					cmd.ev.v1 = wheel;
				end else if (sel == 3'd7) begin
					cmd.ev.ekind = ieq_pkg::EvWheel;
					cmd.ev.v0 = wheel;
				end else begin
					cmd.ev.ekind = ieq_pkg::EvButton;
					cmd.ev.v0 = {29'd0, sel};
					cmd.ev.v1 = {31'd0, bflags_q[db]};
				end
			end
			ieq_pkg::ModeTest: begin
				cmd.ev.source = 1'b1;
				cmd.ev.dkind = tdk_q;
				cmd.ev.ekind = tek_q;
				cmd.ev.flags = 16'd0;
				cmd.ev.id = {24'd0, tdk_q, 24'd0, tek_q};
				cmd.ev.v0 = (tdk_q == ieq_pkg::KindKeyboard) ? 32'h10 : 32'd4;
				cmd.ev.v1 = 32'd1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pend_q <= '0;
			mode_q <= ieq_pkg::ModeKey;
		end else if (take) begin
			busy_q <= 1'b1;
			mode_q <= mode;
			pend_q <= {button_flags[11], button_flags[10],
				|button_flags[9:8], |button_flags[7:6], |button_flags[3:2],
				|button_flags[5:4], |button_flags[1:0],
				(delta_x != 32'd0) || (delta_y != 32'd0)};
		end else if (busy_q) begin
			if (mode_q == ieq_pkg::ModeMouse && pend_q == 8'd0) begin
				busy_q <= 1'b0;
			end else if (cmd_ready) begin
				pend_q <= pend_new;
				if (last) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pflags_q <= packet_flags;
			make_q <= make_code;
			bflags_q <= button_flags;
			bdata_q <= button_data;
			dx_q <= delta_x;
			dy_q <= delta_y;
			id_q <= {device_handle, 16'd0} ^ {48'd0, unit_id};
			t_q <= time_us;
			tdk_q <= test_device_kind;
			tek_q <= test_event_kind;
		end
	end
endmodule

// ===== design/ieq_cmd_queue.sv =====
// Short two-entry queue between the front and the back.
// Depends on ieq_pkg.
module ieq_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ieq_pkg::cmd_t in_cmd,
	output logic          out_valid,
	input  logic          out_ready,
	output ieq_pkg::cmd_t out_cmd
);
	ieq_pkg::cmd_t slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_cmd = slot_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= in_cmd;
	end
endmodule

// ===== design/ieq_back.sv =====
// Back part: circular event store with overwrite of the oldest entry, and reads.
// Depends on ieq_pkg.
module ieq_back #(
	parameter int Depth = ieq_pkg::DefaultDepth
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  ieq_pkg::cmd_t cmd,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          read_status,
	output ieq_pkg::evt_t out_ev
);
	localparam int Aw = $clog2(Depth);
	localparam logic [Aw:0] DepthC = Aw'(0) + (Aw+1)'(Depth);

	ieq_pkg::evt_t mem [Depth];
	logic [Aw-1:0] head_q, tail_q;
	logic [Aw:0]   fill_q;
	logic          rd_pend_s1, rd_empty_s1;
	logic          out_valid_q, status_q;
	ieq_pkg::evt_t rdata_q;
	logic          take, wr, rd;

	// One read in flight at a time; the output register must be free.
	assign cmd_ready = !rd_pend_s1 && !out_valid_q;
	assign take = cmd_valid && cmd_ready;
	assign wr = take && !cmd.is_read;
	assign rd = take && cmd.is_read;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
			rd_pend_s1 <= 1'b0;
			rd_empty_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			status_q <= 1'b0;
		end else begin
			rd_pend_s1 <= rd;
			if (wr) begin
				head_q <= (head_q == Aw'(Depth - 1)) ? '0 : head_q + 1'b1;
				if (fill_q == DepthC)
					tail_q <= (tail_q == Aw'(Depth - 1)) ? '0 : tail_q + 1'b1;
				else
					fill_q <= fill_q + 1'b1;
			end
			if (rd) begin
				rd_empty_s1 <= (fill_q == '0);
				if (fill_q != '0) begin
					tail_q <= (tail_q == Aw'(Depth - 1)) ? '0 : tail_q + 1'b1;
					fill_q <= fill_q - 1'b1;
				end
			end
			if (rd_pend_s1) begin
				out_valid_q <= 1'b1;
				status_q <= rd_empty_s1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The read data is captured with the read and held until the next read.
	always_ff @(posedge clk) begin
		if (wr) mem[head_q] <= cmd.ev;
		if (rd) rdata_q <= mem[tail_q];
	end

	assign out_valid = out_valid_q;
	assign read_status = status_q;
	assign out_ev = status_q ? '0 : rdata_q;
endmodule

// ===== design/input_event_capture_queue_core.sv =====
// Top level of the input event capture queue.
// Depends on ieq_pkg, ieq_front, ieq_cmd_queue and ieq_back.
//
//  channel | direction | contents
//  s_axis  | in        | one packet or read request per word
//  m_axis  | out       | one result word per read request
//
// A keyboard or test word is taken, issued as one event and stored; a mouse
// word issues up to eight events from the front's event sequencer, one event
// per cycle while the queue accepts them. A read result comes from the
// store's registered read port. After reset
// the store is empty; the front stalls while it is still issuing events and
// the back stalls while a read result waits to be taken.
module input_event_capture_queue_core #(
	parameter int QueueDepth = ieq_pkg::DefaultDepth
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata from bit 0: unit_id 16, device_handle 48, packet_flags 16,
	// make_code 16, button_flags 16, button_data 16, delta_x 32, delta_y 32,
	// time_us 64, test_device_kind 8, test_event_kind 8 (272 bits in all)
	input  logic [271:0] s_axis_tdata,
	// tuser: mode
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tdata from bit 0: read_status 1, source 1, device_kind 8, event_kind 8,
	// event_flags 16, device_id 64, instance_hash 64, value0 32, value1 32,
	// value2 16, event_time_us 64, then zero fill to 312 bits
	output logic [311:0] m_axis_tdata
);
	logic          f_valid, f_ready, b_valid, b_ready;
	ieq_pkg::cmd_t f_cmd, b_cmd;
	logic          status;
	ieq_pkg::evt_t ev;
	logic [63:0]   hash;

	ieq_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.mode(s_axis_tuser),
		.unit_id(s_axis_tdata[15:0]),
		.device_handle(s_axis_tdata[63:16]),
		.packet_flags(s_axis_tdata[79:64]),
		.make_code(s_axis_tdata[95:80]),
		.button_flags(s_axis_tdata[111:96]),
		.button_data(s_axis_tdata[127:112]),
		.delta_x(s_axis_tdata[159:128]),
		.delta_y(s_axis_tdata[191:160]),
		.time_us(s_axis_tdata[255:192]),
		.test_device_kind(s_axis_tdata[263:256]),
		.test_event_kind(s_axis_tdata[271:264]),
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
	);

	ieq_cmd_queue u_queue (
		.clk, .arst_n,
		.in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
		.out_valid(b_valid), .out_ready(b_ready), .out_cmd(b_cmd)
	);

	ieq_back #(.Depth(QueueDepth)) u_back (
		.clk, .arst_n,
		.cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.read_status(status), .out_ev(ev)
	);

	// Test events carry the fixed hash; hardware events repeat the device id.
	assign hash = status ? 64'd0 : (ev.source ? ieq_pkg::TestHash : ev.id);

	assign m_axis_tdata = {6'd0, ev.t, ev.v2, ev.v1, ev.v0, hash, ev.id,
		ev.flags, ev.ekind, ev.dkind, ev.source, status};
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the input event capture queue core.
// Depends on ieq_pkg and input_event_capture_queue_core, and through it on ieq_front, ieq_cmd_queue and ieq_back.
`timescale 1ns / 1ps

module tb;
	localparam int Depth = ieq_pkg::DefaultDepth;
	localparam int CycleLimit = 400000;

	// One input word, split into its fields.
	typedef struct {
		logic [1:0]  mode;
		logic [15:0] unit_id;
		logic [47:0] handle;
		logic [15:0] pflags;
		logic [15:0] make;
		logic [15:0] bflags;
		logic [15:0] bdata;
		logic [31:0] dx;
		logic [31:0] dy;
		logic [63:0] time_us;
		logic [7:0]  tdk;
		logic [7:0]  tek;
	} packet_t;

	// One read result, split into its fields.
	typedef struct {
		logic        status;
		logic        source;
		logic [7:0]  dkind;
		logic [7:0]  ekind;
		logic [15:0] flags;
		logic [63:0] id;
		logic [63:0] hash;
		logic [31:0] v0;
		logic [31:0] v1;
		logic [15:0] v2;
		logic [63:0] t;
	} readout_t;

	// A row of the directed table: the word, and a result typed in by hand for
	// reads of an empty store.
	typedef struct {
		packet_t pkt;
		bit      empty_read;
	} row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [271:0] s_axis_tdata = '0;
	logic [1:0]   s_axis_tuser = ieq_pkg::ModeKey;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [311:0] m_axis_tdata;

	ieq_pkg::evt_t event_store[$];   // mirror of the queue contents, oldest first
	readout_t pending_reads[$]; // read results still to come out
	row_t     directed[$];
	int       mismatches = 0;
	int       results_seen = 0;
	int       cycles = 0;
	int       events_made = 0;
	int       events_dropped = 0;
	bit       idle_on = 1'b1;
	bit       hold_req = 1'b0;

	input_event_capture_queue_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #10 clk = ~clk;

	// A generous ceiling on the run; a hang anywhere ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		mismatches++;
		$display("%0t: %s got %h expected %h", $realtime, what, got, want);
	endtask

	// Store one event; a full queue loses its oldest entry first.
	task automatic store_event(input ieq_pkg::evt_t e);
		if (event_store.size() >= Depth) begin
			void'(event_store.pop_front());
			events_dropped++;
		end
		event_store.push_back(e);
		events_made++;
	endtask

	function automatic ieq_pkg::evt_t hw_event(input packet_t p, input logic [7:0] dk,
		input logic [7:0] ek);
		ieq_pkg::evt_t e;
		e = '0;
		e.dkind = dk;
		e.ekind = ek;
		e.flags = p.pflags;
		e.id = {p.handle, 16'h0} ^ {48'h0, p.unit_id};
		e.t = p.time_us;
		return e;
	endfunction

	// Works out what an accepted word does to the queue, and the result of a read.
	task automatic predict_packet(input packet_t p, input bit empty_read);
		ieq_pkg::evt_t e;
		readout_t r;
		logic [15:0] down_mask[5];
		logic [31:0] wheel;
		down_mask = '{16'h0001, 16'h0010, 16'h0004, 16'h0040, 16'h0100};
		wheel = {{16{p.bdata[15]}}, p.bdata};
		case (p.mode)
			ieq_pkg::ModeKey: begin
				e = hw_event(p, ieq_pkg::KindKeyboard, ieq_pkg::EvKey);
				e.v0 = {16'h0, p.make};
				e.v1 = p.pflags[0] ? 32'd0 : 32'd1;
				e.v2 = p.pflags;
				store_event(e);
			end
			ieq_pkg::ModeMouse: begin
				if (p.dx != 0 || p.dy != 0) begin
					e = hw_event(p, ieq_pkg::KindMouse, ieq_pkg::EvMove);
					e.v0 = p.dx;
					e.v1 = p.dy;
					e.v2 = p.pflags;
					store_event(e);
				end
				for (int k = 0; k < 5; k++) begin
					if ((p.bflags & (down_mask[k] | (down_mask[k] << 1))) != 0) begin
						e = hw_event(p, ieq_pkg::KindMouse, ieq_pkg::EvButton);
						e.v0 = k + 1;
						e.v1 = ((p.bflags & down_mask[k]) != 0) ? 32'd1 : 32'd0;
						e.v2 = p.bflags;
						store_event(e);
					end
				end
				if (p.bflags[10]) begin
					e = hw_event(p, ieq_pkg::KindMouse, ieq_pkg::EvWheel);
					e.v0 = 32'd0;
					e.v1 = wheel;
					e.v2 = p.bflags;
					store_event(e);
				end
				if (p.bflags[11]) begin
					e = hw_event(p, ieq_pkg::KindMouse, ieq_pkg::EvWheel);
					e.v0 = wheel;
					e.v1 = 32'd0;
					e.v2 = p.bflags;
					store_event(e);
				end
			end
			ieq_pkg::ModeTest: begin
				e = '0;
				e.source = 1'b1;
				e.dkind = p.tdk;
				e.ekind = p.tek;
				e.id = {24'h0, p.tdk, 24'h0, p.tek};
				e.v0 = (p.tdk == ieq_pkg::KindKeyboard) ? 32'h10 : 32'd4;
				e.v1 = 32'd1;
				e.t = p.time_us;
				store_event(e);
			end
			default: begin
				r = '{default: '0};
				if (empty_read) begin
					// Typed by hand: an empty store answers with the status bit alone.
					r.status = 1'b1;
					if (event_store.size() != 0)
						report("directed row expects an empty store, size", event_store.size(), 0);
				end else if (event_store.size() == 0) begin
					r.status = 1'b1;
				end else begin
					e = event_store.pop_front();
					r.source = e.source;
					r.dkind = e.dkind;
					r.ekind = e.ekind;
					r.flags = e.flags;
					r.id = e.id;
					r.hash = e.source ? ieq_pkg::TestHash : e.id;
					r.v0 = e.v0;
					r.v1 = e.v1;
					r.v2 = e.v2;
					r.t = e.t;
				end
				pending_reads.push_back(r);
			end
		endcase
	endtask

	// Drives one word from a falling edge and returns at the falling edge after
	// it was taken, perhaps after a short gap.
	task automatic send_packet(input packet_t p, input bit empty_read);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= p.mode;
		s_axis_tdata <= {p.tek, p.tdk, p.time_us, p.dy, p.dx, p.bdata, p.bflags, p.make,
			p.pflags, p.handle, p.unit_id};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_packet(p, empty_read);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
	endtask

	function automatic packet_t random_packet(input int read_pct);
		packet_t p;
		int pick;
		p.unit_id = 16'($urandom);
		p.handle = 48'({$urandom, $urandom});
		p.pflags = 16'($urandom);
		p.make = 16'($urandom);
		p.bflags = 16'($urandom);
		p.bdata = 16'($urandom);
		p.dx = $urandom;
		p.dy = $urandom;
		p.time_us = {$urandom, $urandom};
		p.tdk = $urandom_range(0, 3) == 0 ? ieq_pkg::KindKeyboard : 8'($urandom);
		p.tek = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < read_pct)
			p.mode = ieq_pkg::ModeRead;
		else if (pick < read_pct + 20)
			p.mode = ieq_pkg::ModeKey;
		else if (pick < read_pct + 45)
			p.mode = ieq_pkg::ModeMouse;
		else
			p.mode = ieq_pkg::ModeTest;
		// Mouse words with no motion or few buttons are common on a real bus.
		if ($urandom_range(0, 3) == 0) begin
			p.dx = 0;
			p.dy = 0;
		end
		if ($urandom_range(0, 3) == 0)
			p.bflags = p.bflags & 16'($urandom_range(0, 15) << (2 * $urandom_range(0, 6)));
		if ($urandom_range(0, 7) == 0)
			p.dx = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
		return p;
	endfunction

	function automatic row_t mk(input logic [1:0] mode, input logic [15:0] fl,
		input logic [15:0] bf, input logic [15:0] bd, input logic [31:0] dx,
		input logic [31:0] dy, input logic [7:0] tdk, input bit ones, input bit empty_read);
		row_t r;
		r.pkt.mode = mode;
		r.pkt.unit_id = ones ? 16'hFFFF : 16'h0;
		r.pkt.handle = ones ? 48'hFFFF_FFFF_FFFF : 48'h0;
		r.pkt.pflags = fl;
		r.pkt.make = ones ? 16'hFFFF : 16'h0;
		r.pkt.bflags = bf;
		r.pkt.bdata = bd;
		r.pkt.dx = dx;
		r.pkt.dy = dy;
		r.pkt.time_us = ones ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0;
		r.pkt.tdk = tdk;
		r.pkt.tek = ones ? 8'hFF : 8'h0;
		r.empty_read = empty_read;
		return r;
	endfunction

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (600) @(negedge clk);
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 8) - 1) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Result checker: every word taken is held against the oldest expectation.
	always @(posedge clk) begin
		readout_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status = m_axis_tdata[0];
			got.source = m_axis_tdata[1];
			got.dkind = m_axis_tdata[9:2];
			got.ekind = m_axis_tdata[17:10];
			got.flags = m_axis_tdata[33:18];
			got.id = m_axis_tdata[97:34];
			got.hash = m_axis_tdata[161:98];
			got.v0 = m_axis_tdata[193:162];
			got.v1 = m_axis_tdata[225:194];
			got.v2 = m_axis_tdata[241:226];
			got.t = m_axis_tdata[305:242];
			results_seen++;
			if (pending_reads.size() == 0) begin
				report("unexpected result, status", got.status, 0);
			end else begin
				want = pending_reads.pop_front();
				if (got.status !== want.status) report("read_status", got.status, want.status);
				if (got.source !== want.source) report("source", got.source, want.source);
				if (got.dkind !== want.dkind) report("device_kind", got.dkind, want.dkind);
				if (got.ekind !== want.ekind) report("event_kind", got.ekind, want.ekind);
				if (got.flags !== want.flags) report("event_flags", got.flags, want.flags);
				if (got.id !== want.id) report("device_id", got.id, want.id);
				if (got.hash !== want.hash) report("instance_hash", got.hash, want.hash);
				if (got.v0 !== want.v0) report("value0", got.v0, want.v0);
				if (got.v1 !== want.v1) report("value1", got.v1, want.v1);
				if (got.v2 !== want.v2) report("value2", got.v2, want.v2);
				if (got.t !== want.t) report("event_time_us", got.t, want.t);
			end
			if (m_axis_tdata[311:306] !== '0) report("zero fill", m_axis_tdata[311:306], 0);
		end
	end

	initial begin
		packet_t p;
		// Directed rows: extremes of every field, each word kind, both wheel
		// directions, a mouse word that makes no event, and empty reads.
		directed.push_back(mk(ieq_pkg::ModeRead, 16'h0, 16'h0, 16'h0, 0, 0, 0, 0, 1));
		directed.push_back(mk(ieq_pkg::ModeKey, 16'h0, 16'h0, 16'h0, 0, 0, 0, 0, 0));
		directed.push_back(mk(ieq_pkg::ModeKey, 16'hFFFF, 16'h0, 16'h0, 0, 0, 0, 1, 0));
		directed.push_back(mk(ieq_pkg::ModeMouse, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 0, 1, 0));
		directed.push_back(mk(ieq_pkg::ModeMouse, 16'h0, 16'h0, 16'h0, 0, 0, 0, 0, 0));
		directed.push_back(mk(ieq_pkg::ModeMouse, 16'h1, 16'h0400, 16'h8000, 0, 32'h1, 0, 0, 0));
		directed.push_back(mk(ieq_pkg::ModeMouse, 16'h0, 16'hF82A, 16'h7FFF, 0, 0, 0, 1, 0));
		directed.push_back(mk(ieq_pkg::ModeTest, 16'h0, 16'h0, 16'h0, 0, 0,
			ieq_pkg::KindKeyboard, 0, 0));
		directed.push_back(mk(ieq_pkg::ModeTest, 16'h0, 16'h0, 16'h0, 0, 0, 8'hFF, 1, 0));
		// Eighteen events are stored above; the nineteenth read finds the store empty.
		for (int i = 0; i < 19; i++)
			directed.push_back(mk(ieq_pkg::ModeRead, 16'h0, 16'h0, 16'h0, 0, 0, 0, i[0],
				i == 18));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i])
			send_packet(directed[i].pkt, directed[i].empty_read);

		// Overflow the store with full mouse words, then read it out while the
		// receiver holds off, so the block backs up and stalls its input.
		for (int i = 0; i < 24; i++) begin
			p = random_packet(0);
			p.mode = ieq_pkg::ModeMouse;
			p.bflags = 16'h0FFF;
			send_packet(p, 0);
		end
		hold_req = 1'b1;
		for (int i = 0; i < 140; i++) begin
			p = random_packet(100);
			send_packet(p, 0);
		end

		// Sender pause until every read has answered.
		s_axis_tvalid <= 1'b0;
		while (pending_reads.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);

		for (int i = 0; i < 1300; i++) begin
			p = random_packet(40);
			send_packet(p, 0);
		end
		idle_on = 1'b0;
		for (int i = 0; i < 300; i++) begin
			p = random_packet(40);
			send_packet(p, 0);
		end
		s_axis_tvalid <= 1'b0;

		while (pending_reads.size() != 0) @(negedge clk);
		repeat (20) @(posedge clk);
		$display("covered %0d events stored, %0d dropped on overflow, %0d reads checked",
			events_made, events_dropped, results_seen);
		$display("with directed extremes, a long receiver hold-off and a sender pause");
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
